@@ hdl/assert_macros.svh @@
// assertion helpers for the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define HMRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define HMRD_IMPLIES(lbl, pre, post, msg) \
  `HMRD_ASSERT(lbl, (pre) |-> (post), msg)

`endif

@@ hdl/hmrd_pkg.sv @@
package hmrd_pkg;

  localparam int RAW_W  = 16;
  localparam int POS_W  = 10;
  localparam int PROD_W = RAW_W + POS_W;
  // quotient bits resolved by the divider; anything at or above 2**QBITS is flagged up front
  localparam int QBITS  = 11;
  localparam int HI_W   = PROD_W - QBITS;
  // multiply, init, one stage per quotient bit, saturate
  localparam int DIV_ST = QBITS + 3;
  // decode stage plus the divider stages
  localparam int NST    = DIV_ST + 1;
  localparam int CFG_AW = 4;

  localparam logic [POS_W-1:0] SPAN_X   = 10'd1023;
  localparam logic [POS_W-1:0] SPAN_Y   = 10'd767;
  localparam logic [4:0]       BTN_MASK = 5'h1F;
  localparam logic [3:0]       LONG_LEN = 4'd6;

  typedef enum logic [1:0] {
    REG_ABS_MODE,
    REG_REPORT_ID,
    REG_MAX_X,
    REG_MAX_Y
  } reg_idx_t;

  typedef struct packed {
    logic             absolute_mode;
    logic [7:0]       match_id;
    logic [RAW_W-1:0] max_x;
    logic [RAW_W-1:0] max_y;
  } cfg_t;

  typedef struct packed {
    logic              is_absolute;
    logic [4:0]        button_mask;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic signed [7:0] wheel_delta;
  } side_t;

endpackage

@@ hdl/hmrd_cfg.sv @@
module hmrd_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hmrd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hmrd_pkg::cfg_t             cfg_r
);
  import hmrd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.absolute_mode <= 1'b0;
      cfg_r.match_id      <= 8'd0;
      cfg_r.max_x         <= {{(RAW_W-POS_W){1'b0}}, SPAN_X};
      cfg_r.max_y         <= {{(RAW_W-POS_W){1'b0}}, SPAN_Y};
    end else if (wr_en) begin
      unique case (idx)
        REG_ABS_MODE:  cfg_r.absolute_mode <= pwdata[0];
        REG_REPORT_ID: cfg_r.match_id      <= pwdata[7:0];
        REG_MAX_X:     cfg_r.max_x         <= pwdata[RAW_W-1:0];
        REG_MAX_Y:     cfg_r.max_y         <= pwdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ABS_MODE:  prdata = {31'd0, cfg_r.absolute_mode};
      REG_REPORT_ID: prdata = {24'd0, cfg_r.match_id};
      REG_MAX_X:     prdata = {{(32-RAW_W){1'b0}}, cfg_r.max_x};
      REG_MAX_Y:     prdata = {{(32-RAW_W){1'b0}}, cfg_r.max_y};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/hmrd_front.sv @@
module hmrd_front (
  input  logic                      clk,
  input  logic                      adv,
  input  hmrd_pkg::cfg_t            cfg,
  input  logic [7:0]                b0,
  input  logic [7:0]                b1,
  input  logic [7:0]                b2,
  input  logic [7:0]                b3,
  input  logic [7:0]                b4,
  input  logic [7:0]                b5,
  input  logic [3:0]                len,
  output hmrd_pkg::side_t           side_r,
  output logic [hmrd_pkg::RAW_W-1:0] raw_x_r,
  output logic [hmrd_pkg::RAW_W-1:0] raw_y_r,
  output logic [hmrd_pkg::RAW_W-1:0] max_x_r,
  output logic [hmrd_pkg::RAW_W-1:0] max_y_r
);
  import hmrd_pkg::*;

  side_t            side_nxt;
  logic [RAW_W-1:0] raw_x_nxt;
  logic [RAW_W-1:0] raw_y_nxt;
  logic             skip_id;

  function automatic logic signed [7:0] sat127(input logic signed [15:0] v);
    logic signed [7:0] r;
    if (v > 16'sd127) begin
      r = 8'sd127;
    end else if (v < -16'sd127) begin
      r = -8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  assign skip_id = (cfg.match_id != 8'd0) && (b0 == cfg.match_id);

  always_comb begin
    side_nxt  = '0;
    raw_x_nxt = '0;
    raw_y_nxt = '0;
    if (cfg.absolute_mode) begin
      side_nxt.is_absolute = 1'b1;
      if (skip_id) begin
        side_nxt.button_mask = b1[4:0] & BTN_MASK;
        raw_x_nxt            = {b3, b2};
        raw_y_nxt            = {b5, b4};
      end else begin
        side_nxt.button_mask = b0[4:0] & BTN_MASK;
        raw_x_nxt            = {b2, b1};
        raw_y_nxt            = {b4, b3};
      end
    end else begin
      side_nxt.button_mask = b0[4:0] & BTN_MASK;
      if (len == LONG_LEN) begin
        side_nxt.delta_x     = sat127({b2, b1});
        side_nxt.delta_y     = sat127({b4, b3});
        side_nxt.wheel_delta = b5;
      end else begin
        side_nxt.delta_x     = sat127({{8{b1[7]}}, b1});
        side_nxt.delta_y     = sat127({{8{b2[7]}}, b2});
        side_nxt.wheel_delta = b3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r  <= side_nxt;
      raw_x_r <= raw_x_nxt;
      raw_y_r <= raw_y_nxt;
      // zero maximum falls back to the grid span
      max_x_r <= (cfg.max_x == '0) ? {{(RAW_W-POS_W){1'b0}}, SPAN_X} : cfg.max_x;
      max_y_r <= (cfg.max_y == '0) ? {{(RAW_W-POS_W){1'b0}}, SPAN_Y} : cfg.max_y;
    end
  end

endmodule

@@ hdl/hmrd_div.sv @@
module hmrd_div (
  input  logic                        clk,
  input  logic [hmrd_pkg::DIV_ST-1:0] adv,
  input  logic [hmrd_pkg::RAW_W-1:0]  raw,
  input  logic [hmrd_pkg::RAW_W-1:0]  max,
  input  logic [hmrd_pkg::POS_W-1:0]  span,
  output logic [hmrd_pkg::POS_W-1:0]  pos_r
);
  import hmrd_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [RAW_W-1:0]  mm_r;

  logic [RAW_W-1:0]  rem_r [QBITS+1];
  logic [QBITS-1:0]  low_r [QBITS+1];
  logic [QBITS-1:0]  q_r   [QBITS+1];
  logic [RAW_W-1:0]  m_r   [QBITS+1];
  logic              ovf_r [QBITS+1];

  logic [HI_W-1:0]   hi;

  assign hi = prod_r[PROD_W-1:QBITS];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod_r <= PROD_W'(raw) * PROD_W'(span);
      mm_r   <= max;
    end
    // quotient too wide for the step chain is caught here
    if (adv[1]) begin
      rem_r[0] <= {{(RAW_W-HI_W){1'b0}}, hi};
      low_r[0] <= prod_r[QBITS-1:0];
      q_r[0]   <= '0;
      m_r[0]   <= mm_r;
      ovf_r[0] <= {{(RAW_W-HI_W){1'b0}}, hi} >= mm_r;
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_step
    logic [RAW_W:0] trial;
    logic [RAW_W:0] diff;
    logic           ge;

    assign trial = {rem_r[j], low_r[j][QBITS-1]};
    assign diff  = trial - {1'b0, m_r[j]};
    assign ge    = trial >= {1'b0, m_r[j]};

    always_ff @(posedge clk) begin
      if (adv[j+2]) begin
        rem_r[j+1] <= ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
        low_r[j+1] <= {low_r[j][QBITS-2:0], 1'b0};
        q_r[j+1]   <= {q_r[j][QBITS-2:0], ge};
        m_r[j+1]   <= m_r[j];
        ovf_r[j+1] <= ovf_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[QBITS+2]) begin
      if (ovf_r[QBITS] || (q_r[QBITS] > {{(QBITS-POS_W){1'b0}}, span})) begin
        pos_r <= span;
      end else begin
        pos_r <= q_r[QBITS][POS_W-1:0];
      end
    end
  end

endmodule

@@ hdl/hid_mouse_report_decoder_top.sv @@
// stages: decode, then per axis divider multiply, init, quotient steps and saturate
// throughput: one report per cycle while out_stall is low; restoring dividers set the depth
// the input stalls only when every stage holds a word and the output is stalled,
// empty stages still fill while the output waits
// reset (rst_n low, synchronous) empties the pipeline and loads absolute mode 0,
// report id 0, x maximum 1023 and y maximum 767
`include "assert_macros.svh"

module hid_mouse_report_decoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_report_byte0,
  input  logic [7:0]                  in_report_byte1,
  input  logic [7:0]                  in_report_byte2,
  input  logic [7:0]                  in_report_byte3,
  input  logic [7:0]                  in_report_byte4,
  input  logic [7:0]                  in_report_byte5,
  input  logic [3:0]                  in_received_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_absolute,
  output logic [4:0]                  out_button_mask,
  output logic [hmrd_pkg::POS_W-1:0]  out_position_x,
  output logic [hmrd_pkg::POS_W-1:0]  out_position_y,
  output logic signed [7:0]           out_delta_x,
  output logic signed [7:0]           out_delta_y,
  output logic signed [7:0]           out_wheel_delta,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmrd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hmrd_pkg::*;

  cfg_t             cfg;
  logic [NST-1:0]   v_r;
  logic [NST:0]     rdy;
  logic [NST-1:0]   v_in;
  side_t            side_r [NST];
  logic [RAW_W-1:0] raw_x, raw_y, max_x, max_y;
  logic             rel_out, abs_out, pos_zero, delta_zero;

  hmrd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_r   (cfg)
  );

  // a stage takes a new word when it is empty or its successor moves on
  assign rdy[NST] = !out_stall;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign v_in     = {v_r[NST-2:0], in_valid};
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  hmrd_front u_front (
    .clk     (clk),
    .adv     (rdy[0]),
    .cfg     (cfg),
    .b0      (in_report_byte0),
    .b1      (in_report_byte1),
    .b2      (in_report_byte2),
    .b3      (in_report_byte3),
    .b4      (in_report_byte4),
    .b5      (in_report_byte5),
    .len     (in_received_length),
    .side_r  (side_r[0]),
    .raw_x_r (raw_x),
    .raw_y_r (raw_y),
    .max_x_r (max_x),
    .max_y_r (max_y)
  );

  // buttons and deltas ride alongside the divider
  for (genvar k = 1; k < NST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  hmrd_div u_div_x (
    .clk   (clk),
    .adv   (rdy[NST-1:1]),
    .raw   (raw_x),
    .max   (max_x),
    .span  (SPAN_X),
    .pos_r (out_position_x)
  );

  hmrd_div u_div_y (
    .clk   (clk),
    .adv   (rdy[NST-1:1]),
    .raw   (raw_y),
    .max   (max_y),
    .span  (SPAN_Y),
    .pos_r (out_position_y)
  );

  assign out_valid       = v_r[NST-1];
  assign out_is_absolute = side_r[NST-1].is_absolute;
  assign out_button_mask = side_r[NST-1].button_mask;
  assign out_delta_x     = side_r[NST-1].delta_x;
  assign out_delta_y     = side_r[NST-1].delta_y;
  assign out_wheel_delta = side_r[NST-1].wheel_delta;

  assign rel_out    = out_valid && !out_is_absolute;
  assign abs_out    = out_valid && out_is_absolute;
  assign pos_zero   = (out_position_x == '0) && (out_position_y == '0);
  assign delta_zero = (out_delta_x == 8'sd0) && (out_delta_y == 8'sd0) &&
                      (out_wheel_delta == 8'sd0);

  `HMRD_IMPLIES(a_stall_only_when_full, in_stall, out_valid && out_stall, "stall with room")
  `HMRD_IMPLIES(a_rel_no_position, rel_out, pos_zero, "relative word carries position")
  `HMRD_IMPLIES(a_abs_no_delta, abs_out, delta_zero, "absolute word carries deltas")
  `HMRD_IMPLIES(a_y_in_span, out_valid, out_position_y <= SPAN_Y, "y position beyond span")

endmodule
